// ----- hdl/pipc_pkg.sv -----
package pipc_pkg;

    localparam int ADC_W   = 12;
    localparam int POS_W   = 32;
    localparam int TIME_W  = 32;
    localparam int GAIN_W  = 16;
    localparam int DIR_W   = 2;
    localparam int CFG_W   = 16;
    localparam int CIDX_W  = 2;
    localparam int ERR_W   = 8;
    localparam int ACC_W   = 48;
    localparam int MCNT_W  = 4;

    localparam logic [CIDX_W-1:0] CFG_PROP_GAIN  = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_INTEG_GAIN = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_DIRECTION  = 2'd2;

    localparam logic signed [POS_W:0] ERR_UPPER     = 33'sd100;
    localparam logic signed [POS_W:0] ERR_LOWER     = -33'sd100;
    localparam logic signed [ERR_W-1:0] ERR_UPPER_SAT = 8'sd99;
    localparam logic signed [ERR_W-1:0] ERR_LOWER_SAT = -8'sd99;

    localparam logic [TIME_W-1:0] TIMER_WRAP = 32'hFFFF_FFFF;

    localparam logic signed [ACC_W-1:0] SAT_MAX = 48'sh0000_7FFF_FFFF;
    localparam logic signed [ACC_W-1:0] SAT_MIN = -48'sh0000_8000_0000;

    localparam logic [MCNT_W-1:0] MUL_ERR_LAST  = 4'(ERR_W - 1);
    localparam logic [MCNT_W-1:0] MUL_GAIN_LAST = 4'(GAIN_W - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_INT_MUL,
        ST_INT_SAT,
        ST_DRV_MUL,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

// ----- hdl/pipc_in_if.sv -----
interface pipc_in_if;
    logic                                valid;
    logic                                ready;
    logic [pipc_pkg::ADC_W-1:0]          adc_sample;
    logic signed [pipc_pkg::POS_W-1:0]   encoder_count;
    logic [pipc_pkg::TIME_W-1:0]         timer_count;

    modport source (output valid, adc_sample, encoder_count, timer_count, input ready);
    modport sink   (input valid, adc_sample, encoder_count, timer_count, output ready);
endinterface

// ----- hdl/pipc_out_if.sv -----
interface pipc_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [pipc_pkg::POS_W-1:0]   drive_value;
    logic                                enable_cmd;

    modport source (output valid, drive_value, enable_cmd, input ready);
    modport sink   (input valid, drive_value, enable_cmd, output ready);
endinterface

// ----- hdl/pi_position_controller_unit.sv -----
// pi position loop for one motor
// input channel i_in: one word per control sample with the converter setpoint,
// the encoder count and a free-running timer value. output channel o_out: one
// word with the saturated drive value and the enable flag.
// the first word after reset only captures the converter zero point and
// returns enable_cmd = 1 with drive_value = 0. later words return a drive
// update; a word whose timer shows no elapsed ticks gives no result and the
// block stays idle with the input ready. a drive update runs through the
// bit-serial divider for the elapsed ticks and the shared shift-add
// multiplier, one multiplier bit per cycle: first error times the divided
// ticks, then the integral times the integral gain.
// one word at a time is in work; the result sits in an output register, so
// the next word is accepted while it waits for the receiver. when the
// receiver stalls and the register is still full, the next finished result
// waits in the block and the input stays not ready.
// reset (synchronous, active low) clears the gains to zero, direction to 1,
// the integral, the timer history and the zero-point capture. unenforced, the
// user writes config through i_cfg_we/i_cfg_index/i_cfg_data only while idle.
module pi_position_controller_unit #(
    parameter int TIME_DIVISOR = 1000
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [pipc_pkg::CIDX_W-1:0]           i_cfg_index,
    input  logic [pipc_pkg::CFG_W-1:0]            i_cfg_data,
    pipc_in_if.sink                               i_in,
    pipc_out_if.source                            o_out
);

    typedef struct packed {
        logic in_ready;
        logic capture;
        logic update;
        logic div_start;
        logic load_int;
        logic mac_step;
        logic load_drv;
        logic emit;
    } t_ctl;

    pipc_pkg::t_state                          r_state;
    pipc_pkg::t_state                          n_state;
    t_ctl                                      w_ctl;

    logic signed [pipc_pkg::GAIN_W-1:0]        r_kp;
    logic signed [pipc_pkg::GAIN_W-1:0]        r_ki;
    logic signed [pipc_pkg::DIR_W-1:0]         r_dir;

    logic                                      r_started;
    logic [pipc_pkg::ADC_W-1:0]                r_pot_zero;
    logic signed [pipc_pkg::POS_W-1:0]         r_integral;
    logic [pipc_pkg::TIME_W-1:0]               r_last_time;
    logic signed [pipc_pkg::ERR_W-1:0]         r_err;
    logic                                      r_en_flag;

    logic signed [pipc_pkg::ACC_W-1:0]         r_acc;
    logic [pipc_pkg::ACC_W-1:0]                r_mcand;
    logic [pipc_pkg::GAIN_W-1:0]               r_mplier;
    logic [pipc_pkg::MCNT_W-1:0]               r_cnt;
    logic [pipc_pkg::MCNT_W-1:0]               r_last;

    logic                                      r_out_valid;
    logic signed [pipc_pkg::POS_W-1:0]         r_out_drive;
    logic                                      r_out_en;

    logic                                      w_in_acc;
    logic                                      w_slot_free;
    logic signed [pipc_pkg::ADC_W:0]           w_diff;
    logic signed [14:0]                        w_dir_x;
    logic signed [14:0]                        w_diff_x;
    logic signed [14:0]                        w_target;
    logic signed [pipc_pkg::POS_W:0]           w_err_full;
    logic signed [pipc_pkg::ERR_W-1:0]         w_err_clamp;
    logic [pipc_pkg::TIME_W-1:0]               w_elapsed;
    logic                                      w_elapsed_nz;
    logic                                      w_mul_last;
    logic [pipc_pkg::ACC_W-1:0]                w_addend;
    logic signed [pipc_pkg::ACC_W-1:0]         w_acc_step;
    logic signed [pipc_pkg::POS_W-1:0]         w_acc_sat;
    logic signed [pipc_pkg::GAIN_W+pipc_pkg::ERR_W-1:0] w_kp_err;

    pipc_pkg::t_div_stat                       w_div_stat;
    logic [pipc_pkg::TIME_W-1:0]               w_quot;

    pipc_bit_divider #(
        .DIVISOR (TIME_DIVISOR)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_ctl.div_start),
        .i_dividend (w_elapsed),
        .o_stat     (w_div_stat),
        .o_quotient (w_quot)
    );

    assign w_in_acc    = i_in.valid && w_ctl.in_ready;
    assign w_slot_free = !r_out_valid || o_out.ready;

    // target and clamped position error
    assign w_diff     = $signed({1'b0, i_in.adc_sample}) - $signed({1'b0, r_pot_zero});
    assign w_dir_x    = {{13{r_dir[pipc_pkg::DIR_W-1]}}, r_dir};
    assign w_diff_x   = {{2{w_diff[pipc_pkg::ADC_W]}}, w_diff};
    assign w_target   = w_dir_x * w_diff_x;
    assign w_err_full = {{18{w_target[14]}}, w_target}
                      - {i_in.encoder_count[pipc_pkg::POS_W-1], i_in.encoder_count};

    always_comb begin
        if (w_err_full > pipc_pkg::ERR_UPPER) begin
            w_err_clamp = pipc_pkg::ERR_UPPER_SAT;
        end else if (w_err_full < pipc_pkg::ERR_LOWER) begin
            w_err_clamp = pipc_pkg::ERR_LOWER_SAT;
        end else begin
            w_err_clamp = w_err_full[pipc_pkg::ERR_W-1:0];
        end
    end

    assign w_elapsed = (i_in.timer_count >= r_last_time)
                     ? (i_in.timer_count - r_last_time)
                     : (pipc_pkg::TIMER_WRAP - r_last_time + i_in.timer_count);
    assign w_elapsed_nz = (w_elapsed != '0);

    // shift-add multiplier, top multiplier bit carries negative weight
    assign w_mul_last = (r_cnt == r_last);
    assign w_addend   = r_mplier[0] ? r_mcand : '0;
    assign w_acc_step = w_mul_last ? (r_acc - $signed(w_addend))
                                   : (r_acc + $signed(w_addend));
    assign w_kp_err   = r_kp * r_err;

    always_comb begin
        if (r_acc > pipc_pkg::SAT_MAX) begin
            w_acc_sat = pipc_pkg::SAT_MAX[pipc_pkg::POS_W-1:0];
        end else if (r_acc < pipc_pkg::SAT_MIN) begin
            w_acc_sat = pipc_pkg::SAT_MIN[pipc_pkg::POS_W-1:0];
        end else begin
            w_acc_sat = r_acc[pipc_pkg::POS_W-1:0];
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pipc_pkg::ST_IDLE: begin
                if (w_in_acc) begin
                    if (!r_started) begin
                        n_state = pipc_pkg::ST_EMIT;
                    end else if (w_elapsed_nz) begin
                        n_state = pipc_pkg::ST_DIV;
                    end
                end
            end
            pipc_pkg::ST_DIV: begin
                if (w_div_stat.done) begin
                    n_state = pipc_pkg::ST_INT_MUL;
                end
            end
            pipc_pkg::ST_INT_MUL: begin
                if (w_mul_last) begin
                    n_state = pipc_pkg::ST_INT_SAT;
                end
            end
            pipc_pkg::ST_INT_SAT: begin
                n_state = pipc_pkg::ST_DRV_MUL;
            end
            pipc_pkg::ST_DRV_MUL: begin
                if (w_mul_last) begin
                    n_state = pipc_pkg::ST_EMIT;
                end
            end
            pipc_pkg::ST_EMIT: begin
                if (w_slot_free) begin
                    n_state = pipc_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = pipc_pkg::ST_IDLE;
            end
        endcase
    end

    // control outputs
    always_comb begin
        w_ctl = '0;
        unique case (r_state)
            pipc_pkg::ST_IDLE: begin
                w_ctl.in_ready  = 1'b1;
                w_ctl.capture   = i_in.valid && !r_started;
                w_ctl.update    = i_in.valid && r_started;
                w_ctl.div_start = i_in.valid && r_started && w_elapsed_nz;
            end
            pipc_pkg::ST_DIV: begin
                w_ctl.load_int = w_div_stat.done;
            end
            pipc_pkg::ST_INT_MUL: begin
                w_ctl.mac_step = 1'b1;
            end
            pipc_pkg::ST_INT_SAT: begin
                w_ctl.load_drv = 1'b1;
            end
            pipc_pkg::ST_DRV_MUL: begin
                w_ctl.mac_step = 1'b1;
            end
            pipc_pkg::ST_EMIT: begin
                w_ctl.emit = w_slot_free;
            end
            default: begin
                w_ctl = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pipc_pkg::ST_IDLE;
            r_kp        <= '0;
            r_ki        <= '0;
            r_dir       <= 2'sd1;
            r_started   <= 1'b0;
            r_pot_zero  <= '0;
            r_integral  <= '0;
            r_last_time <= '0;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    pipc_pkg::CFG_PROP_GAIN:  r_kp  <= i_cfg_data;
                    pipc_pkg::CFG_INTEG_GAIN: r_ki  <= i_cfg_data;
                    pipc_pkg::CFG_DIRECTION:  r_dir <= i_cfg_data[pipc_pkg::DIR_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (w_ctl.capture) begin
                r_started  <= 1'b1;
                r_pot_zero <= i_in.adc_sample;
            end
            if (w_ctl.capture || w_ctl.update) begin
                r_last_time <= i_in.timer_count;
            end
            if (w_ctl.load_drv) begin
                r_integral <= w_acc_sat;
            end
            if (w_ctl.load_int || w_ctl.load_drv) begin
                r_cnt <= '0;
            end else if (w_ctl.mac_step) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (w_ctl.emit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctl.capture) begin
            r_acc     <= '0;
            r_en_flag <= 1'b1;
        end
        if (w_ctl.update) begin
            r_err     <= w_err_clamp;
            r_en_flag <= 1'b0;
        end
        if (w_ctl.load_int) begin
            r_acc    <= {{16{r_integral[pipc_pkg::POS_W-1]}}, r_integral};
            r_mcand  <= {16'b0, w_quot};
            r_mplier <= {{8{r_err[pipc_pkg::ERR_W-1]}}, r_err};
            r_last   <= pipc_pkg::MUL_ERR_LAST;
        end
        if (w_ctl.mac_step) begin
            r_acc    <= w_acc_step;
            r_mcand  <= {r_mcand[pipc_pkg::ACC_W-2:0], 1'b0};
            r_mplier <= {1'b0, r_mplier[pipc_pkg::GAIN_W-1:1]};
        end
        if (w_ctl.load_drv) begin
            r_acc    <= {{24{w_kp_err[23]}}, w_kp_err};
            r_mcand  <= {{16{w_acc_sat[pipc_pkg::POS_W-1]}}, w_acc_sat};
            r_mplier <= r_ki;
            r_last   <= pipc_pkg::MUL_GAIN_LAST;
        end
        if (w_ctl.emit) begin
            r_out_drive <= w_acc_sat;
            r_out_en    <= r_en_flag;
        end
    end

    assign i_in.ready        = w_ctl.in_ready;
    assign o_out.valid       = r_out_valid;
    assign o_out.drive_value = r_out_drive;
    assign o_out.enable_cmd  = r_out_en;

`ifndef SYNTH
    a_enable_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_en) |-> (r_out_drive == '0))
        else $error("enable word with nonzero drive");

    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_stat.done |-> (r_state == pipc_pkg::ST_DIV))
        else $error("divider finished outside its phase");

    a_first_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && !r_started) |=> (r_started && r_state == pipc_pkg::ST_EMIT))
        else $error("first word did not capture the zero point");

    a_err_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pipc_pkg::ST_INT_MUL) |-> (r_err <= 8'sd100 && r_err >= -8'sd100))
        else $error("clamped error out of range");

    a_no_idle_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pipc_pkg::ST_IDLE) |-> !w_div_stat.busy)
        else $error("divider busy while idle");
`endif

endmodule

// ----- hdl/pipc_bit_divider.sv -----
module pipc_bit_divider #(
    parameter int DIVISOR = 1000
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic [pipc_pkg::TIME_W-1:0]        i_dividend,
    output pipc_pkg::t_div_stat                o_stat,
    output logic [pipc_pkg::TIME_W-1:0]        o_quotient
);

    localparam int RW = $clog2(DIVISOR) + 1;
    localparam int CW = $clog2(pipc_pkg::TIME_W);
    localparam logic [RW:0]   DIV_EXT  = (RW+1)'(DIVISOR);
    localparam logic [CW-1:0] CNT_LAST = CW'(pipc_pkg::TIME_W - 1);

    logic                          r_busy;
    logic                          r_done;
    logic [CW-1:0]                 r_cnt;
    logic [pipc_pkg::TIME_W-1:0]   r_word;
    logic [RW-1:0]                 r_rem;

    logic [RW:0]                   w_trial;
    logic [RW:0]                   w_diff;
    logic                          w_qbit;
    logic [RW-1:0]                 n_rem;

    // one quotient bit per cycle, restoring form
    assign w_trial = {r_rem, r_word[pipc_pkg::TIME_W-1]};
    assign w_qbit  = (w_trial >= DIV_EXT);
    assign w_diff  = w_trial - DIV_EXT;
    assign n_rem   = w_qbit ? w_diff[RW-1:0] : w_trial[RW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // dividend shifts out the top while quotient bits enter at the bottom
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_word <= i_dividend;
            r_rem  <= '0;
        end else if (r_busy) begin
            r_word <= {r_word[pipc_pkg::TIME_W-2:0], w_qbit};
            r_rem  <= n_rem;
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quotient  = r_word;

endmodule
